// ===== rtl/core/lsd_pkg.sv =====
// Shared types, constants and codes for the least loaded slot dispatcher.
`timescale 1ns / 1ps
package lsd_pkg;

  localparam int DEF_MAX_QUEUES      = 8;
  localparam int DEF_SLOTS_PER_QUEUE = 8;

  localparam int UNIT_W     = 30;
  localparam int SLICE_W    = 33;
  localparam int LOAD_W     = 36;
  localparam int AQ_W       = 4;
  localparam int FREE_OUT_W = 7;
  localparam int SEL_W      = 3;

  localparam logic [LOAD_W-1:0] ZERO_SLICE_SCORE = LOAD_W'(999);
  localparam logic [AQ_W-1:0]   ACTIVE_QUEUES_RST = AQ_W'(8);
  localparam logic [UNIT_W-1:0] SLICE_UNIT_RST    = UNIT_W'(1000000);

  localparam logic FUNC_DISPATCH = 1'b0;
  localparam logic FUNC_COMPLETE = 1'b1;

  localparam logic [1:0] PRIO_NONE = 2'd0;
  localparam logic [1:0] PRIO_HIGH = 2'd1;
  localparam logic [1:0] PRIO_MID  = 2'd2;
  localparam logic [1:0] PRIO_LOW  = 2'd3;

  localparam logic CFG_ACTIVE_QUEUES = 1'b0;
  localparam logic CFG_SLICE_UNIT    = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } lsd_state_t;

  typedef struct packed {
    logic valid;
    logic last;
    logic busy;
    logic active;
    logic cand;
  } lsd_scan_ctrl_t;

endpackage

// ===== rtl/core/lsd_slice_mem.sv =====
// Slice memory: one write port and one registered read port.
`timescale 1ns / 1ps
module lsd_slice_mem #(
  parameter int AW = 6,
  parameter int DW = 33
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  localparam int DEPTH = 1 << AW;

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/lsd_score_unit.sv =====
// Shared score accumulator with the running least-load compare and free slot count.
`timescale 1ns / 1ps
module lsd_score_unit #(
  parameter int QW = 3,
  parameter int SW = 3,
  parameter int FW = 7
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       clear,
  input  lsd_pkg::lsd_scan_ctrl_t    ctrl,
  input  logic [QW-1:0]              q,
  input  logic [SW-1:0]              s,
  input  logic [lsd_pkg::SLICE_W-1:0] rdata,
  output logic                       found,
  output logic [lsd_pkg::LOAD_W-1:0] best_score,
  output logic [QW-1:0]              best_q,
  output logic [SW-1:0]              best_s,
  output logic [FW-1:0]              free_cnt
);

  logic [lsd_pkg::LOAD_W-1:0] acc_r, acc_nxt, acc_base, term;
  logic                       done_r, done_nxt;
  logic                       cand_r, cand_nxt;
  logic [QW-1:0]              qd_r, qd_nxt;
  logic                       ff_found_r, ff_found_nxt, ff_found_base;
  logic [SW-1:0]              ff_slot_r, ff_slot_nxt;
  logic                       found_r, found_nxt;
  logic [lsd_pkg::LOAD_W-1:0] best_r, best_nxt;
  logic [QW-1:0]              best_q_r, best_q_nxt;
  logic [SW-1:0]              best_s_r, best_s_nxt;
  logic [FW-1:0]              free_r, free_nxt;

  always_comb begin
    if (!ctrl.busy) begin
      term = '0;
    end else if (rdata == '0) begin
      term = lsd_pkg::ZERO_SLICE_SCORE;
    end else begin
      term = lsd_pkg::LOAD_W'(rdata);
    end
    acc_base      = done_r ? '0 : acc_r;
    ff_found_base = done_r ? 1'b0 : ff_found_r;
    acc_nxt       = acc_base;
    ff_found_nxt  = ff_found_base;
    ff_slot_nxt   = ff_slot_r;
    done_nxt      = 1'b0;
    cand_nxt      = cand_r;
    qd_nxt        = qd_r;
    free_nxt      = free_r;
    if (ctrl.valid) begin
      acc_nxt  = acc_base + term;
      done_nxt = ctrl.last;
      cand_nxt = ctrl.cand;
      qd_nxt   = q;
      if (!ff_found_base && !ctrl.busy) begin
        ff_found_nxt = 1'b1;
        ff_slot_nxt  = s;
      end
      if (ctrl.active && !ctrl.busy) begin
        free_nxt = free_r + FW'(1);
      end
    end
    found_nxt  = found_r;
    best_nxt   = best_r;
    best_q_nxt = best_q_r;
    best_s_nxt = best_s_r;
    if (done_r && cand_r && (!found_r || acc_r < best_r)) begin
      found_nxt  = 1'b1;
      best_nxt   = acc_r;
      best_q_nxt = qd_r;
      best_s_nxt = ff_slot_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      acc_r      <= '0;
      done_r     <= 1'b0;
      cand_r     <= 1'b0;
      ff_found_r <= 1'b0;
      found_r    <= 1'b0;
      free_r     <= '0;
    end else begin
      acc_r      <= acc_nxt;
      done_r     <= done_nxt;
      cand_r     <= cand_nxt;
      ff_found_r <= ff_found_nxt;
      found_r    <= found_nxt;
      free_r     <= free_nxt;
    end
  end

  always_ff @(posedge clk) begin
    qd_r      <= qd_nxt;
    ff_slot_r <= ff_slot_nxt;
    best_r    <= best_nxt;
    best_q_r  <= best_q_nxt;
    best_s_r  <= best_s_nxt;
  end

  assign found      = found_r;
  assign best_score = best_r;
  assign best_q     = best_q_r;
  assign best_s     = best_s_r;
  assign free_cnt   = free_r;

endmodule

// ===== rtl/core/least_loaded_slot_dispatcher_unit.sv =====
// Top level of the least loaded slot dispatcher: sequencer, slot table and ports.
//
// A word is taken on the in_ ports at a clock edge where start is high and busy
// is low. Function dispatch places a job in the first free slot of the active,
// not full queue with the lowest load; function complete frees one given slot.
// Every word gives exactly one result word, shown on the out_ ports for one cycle
// while out_valid is high. The receiver cannot stall, so nothing is held back.
// Each word passes through the scan, drain and finish states before out_valid:
// the scan reads every slot's slice from the slice memory once, one slot per cycle
// through the single read port, and sums it in one shared accumulator. busy stays
// high from acceptance until the result is formed; a new word may be started in
// the cycle that shows the previous result. The cfg_ port writes active_queues
// (index 0) and slice_unit (index 1); cfg_ready is always high. The user must
// see that writes are made only while busy is low; the block itself does not
// enforce it. Synchronous reset frees every slot and loads active_queues with 8
// and slice_unit with 1000000. The slice memory needs no clearing: only busy slots,
// which were written when their job was placed, are ever read into a score.
`timescale 1ns / 1ps
module least_loaded_slot_dispatcher_unit #(
  parameter int MAX_QUEUES      = lsd_pkg::DEF_MAX_QUEUES,
  parameter int SLOTS_PER_QUEUE = lsd_pkg::DEF_SLOTS_PER_QUEUE
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_func,
  input  logic [1:0]                     in_priority_req,
  input  logic [lsd_pkg::SEL_W-1:0]      in_queue_sel,
  input  logic [lsd_pkg::SEL_W-1:0]      in_slot_sel,
  output logic                           out_valid,
  output logic                           out_accepted,
  output logic [lsd_pkg::SEL_W-1:0]      out_chosen_queue,
  output logic [lsd_pkg::SEL_W-1:0]      out_chosen_slot,
  output logic [lsd_pkg::SLICE_W-1:0]    out_assigned_slice,
  output logic [lsd_pkg::LOAD_W-1:0]     out_queue_load,
  output logic [lsd_pkg::FREE_OUT_W-1:0] out_free_slots,
  output logic                           out_error_flag,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_index,
  input  logic [lsd_pkg::UNIT_W-1:0]     cfg_data
);

  localparam int QW    = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
  localparam int SW    = (SLOTS_PER_QUEUE > 1) ? $clog2(SLOTS_PER_QUEUE) : 1;
  localparam int NQW   = $clog2(MAX_QUEUES + 1);
  localparam int TOTAL = MAX_QUEUES * SLOTS_PER_QUEUE;
  localparam int FW    = $clog2(TOTAL + 1);

  lsd_pkg::lsd_state_t state_r, state_nxt;

  logic [lsd_pkg::AQ_W-1:0]   active_queues_r;
  logic [lsd_pkg::UNIT_W-1:0] slice_unit_r;
  logic [NQW-1:0]             nq;

  logic                        func_r;
  logic [lsd_pkg::SEL_W-1:0]   qsel_r, ssel_r;
  logic [lsd_pkg::SLICE_W-1:0] slice_r, slice_nxt;

  logic [MAX_QUEUES-1:0][SLOTS_PER_QUEUE-1:0] busy_r;

  logic [QW-1:0] q_r;
  logic [SW-1:0] s_r;
  logic          drain_r;
  logic          last_s, last_q;

  lsd_pkg::lsd_scan_ctrl_t ctrl_now, ctrl_d_r;
  logic [QW-1:0]           q_d_r;
  logic [SW-1:0]           s_d_r;

  logic                        mem_wr_en;
  logic [QW+SW-1:0]            mem_wr_addr;
  logic [lsd_pkg::SLICE_W-1:0] mem_rdata;

  logic                       found;
  logic [lsd_pkg::LOAD_W-1:0] best_score;
  logic [QW-1:0]              best_q;
  logic [SW-1:0]              best_s;
  logic [FW-1:0]              free_cnt;

  logic          accept;
  logic          cq_ok, cs_ok, comp_ok;
  logic [QW-1:0] cq_idx;
  logic [SW-1:0] cs_idx;
  logic          set_busy, clr_busy;

  logic                           out_valid_r;
  logic                           out_accepted_r, out_accepted_nxt;
  logic [lsd_pkg::SEL_W-1:0]      out_cq_r, out_cq_nxt;
  logic [lsd_pkg::SEL_W-1:0]      out_cs_r, out_cs_nxt;
  logic [lsd_pkg::SLICE_W-1:0]    out_slice_r, out_slice_nxt;
  logic [lsd_pkg::LOAD_W-1:0]     out_load_r, out_load_nxt;
  logic [lsd_pkg::FREE_OUT_W-1:0] out_free_r, out_free_nxt;
  logic                           out_err_r, out_err_nxt;

  assign accept    = start && (state_r == lsd_pkg::ST_IDLE);
  assign busy      = (state_r != lsd_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  assign nq = (5'(active_queues_r) < 5'(MAX_QUEUES)) ? NQW'(active_queues_r)
                                                     : NQW'(MAX_QUEUES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_queues_r <= lsd_pkg::ACTIVE_QUEUES_RST;
      slice_unit_r    <= lsd_pkg::SLICE_UNIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lsd_pkg::CFG_ACTIVE_QUEUES: active_queues_r <= cfg_data[lsd_pkg::AQ_W-1:0];
        lsd_pkg::CFG_SLICE_UNIT:    slice_unit_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (in_priority_req)
      lsd_pkg::PRIO_HIGH: slice_nxt = (lsd_pkg::SLICE_W'(slice_unit_r) << 2)
                                    + (lsd_pkg::SLICE_W'(slice_unit_r) << 1);
      lsd_pkg::PRIO_MID:  slice_nxt = lsd_pkg::SLICE_W'(slice_unit_r) << 2;
      lsd_pkg::PRIO_LOW:  slice_nxt = lsd_pkg::SLICE_W'(slice_unit_r) << 1;
      default:            slice_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r  <= in_func;
      qsel_r  <= in_queue_sel;
      ssel_r  <= in_slot_sel;
      slice_r <= slice_nxt;
    end
  end

  assign last_s = (s_r == SW'(SLOTS_PER_QUEUE - 1));
  assign last_q = (q_r == QW'(MAX_QUEUES - 1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lsd_pkg::ST_IDLE:   if (start) state_nxt = lsd_pkg::ST_SCAN;
      lsd_pkg::ST_SCAN:   if (last_s && last_q) state_nxt = lsd_pkg::ST_DRAIN;
      lsd_pkg::ST_DRAIN:  if (drain_r) state_nxt = lsd_pkg::ST_FINISH;
      lsd_pkg::ST_FINISH: state_nxt = lsd_pkg::ST_IDLE;
      default:            state_nxt = lsd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lsd_pkg::ST_IDLE;
      q_r     <= '0;
      s_r     <= '0;
      drain_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      drain_r <= (state_r == lsd_pkg::ST_DRAIN) && !drain_r;
      if (accept) begin
        q_r <= '0;
        s_r <= '0;
      end else if (state_r == lsd_pkg::ST_SCAN) begin
        if (last_s) begin
          s_r <= '0;
          q_r <= q_r + QW'(1);
        end else begin
          s_r <= s_r + SW'(1);
        end
      end
    end
  end

  always_comb begin
    ctrl_now.valid  = (state_r == lsd_pkg::ST_SCAN);
    ctrl_now.last   = last_s;
    ctrl_now.busy   = busy_r[q_r][s_r];
    ctrl_now.active = (NQW'(q_r) < nq);
    ctrl_now.cand   = ctrl_now.active && !(&busy_r[q_r]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_d_r <= '0;
    end else begin
      ctrl_d_r <= ctrl_now;
    end
  end

  always_ff @(posedge clk) begin
    q_d_r <= q_r;
    s_d_r <= s_r;
  end

  lsd_slice_mem #(
    .AW(QW + SW),
    .DW(lsd_pkg::SLICE_W)
  ) u_slice_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (slice_r),
    .rd_addr ({q_r, s_r}),
    .rd_data (mem_rdata)
  );

  lsd_score_unit #(
    .QW(QW),
    .SW(SW),
    .FW(FW)
  ) u_score (
    .clk        (clk),
    .rst_n      (rst_n),
    .clear      (accept),
    .ctrl       (ctrl_d_r),
    .q          (q_d_r),
    .s          (s_d_r),
    .rdata      (mem_rdata),
    .found      (found),
    .best_score (best_score),
    .best_q     (best_q),
    .best_s     (best_s),
    .free_cnt   (free_cnt)
  );

  assign cq_ok   = (5'(qsel_r) < 5'(nq));
  assign cs_ok   = (6'(ssel_r) < 6'(SLOTS_PER_QUEUE));
  assign cq_idx  = QW'(qsel_r);
  assign cs_idx  = SW'(ssel_r);
  assign comp_ok = cq_ok && cs_ok && busy_r[cq_idx][cs_idx];

  always_comb begin
    set_busy         = 1'b0;
    clr_busy         = 1'b0;
    mem_wr_en        = 1'b0;
    mem_wr_addr      = {best_q, best_s};
    out_accepted_nxt = 1'b0;
    out_cq_nxt       = '0;
    out_cs_nxt       = '0;
    out_slice_nxt    = '0;
    out_load_nxt     = '0;
    out_free_nxt     = lsd_pkg::FREE_OUT_W'(free_cnt);
    out_err_nxt      = 1'b0;
    if (state_r == lsd_pkg::ST_FINISH) begin
      unique case (func_r)
        lsd_pkg::FUNC_DISPATCH: begin
          if (found) begin
            set_busy         = 1'b1;
            mem_wr_en        = 1'b1;
            out_accepted_nxt = 1'b1;
            out_cq_nxt       = lsd_pkg::SEL_W'(best_q);
            out_cs_nxt       = lsd_pkg::SEL_W'(best_s);
            out_slice_nxt    = slice_r;
            out_load_nxt     = best_score;
            out_free_nxt     = lsd_pkg::FREE_OUT_W'(free_cnt - FW'(1));
          end else begin
            out_err_nxt = 1'b1;
          end
        end
        lsd_pkg::FUNC_COMPLETE: begin
          if (comp_ok) begin
            clr_busy         = 1'b1;
            out_accepted_nxt = 1'b1;
            out_free_nxt     = lsd_pkg::FREE_OUT_W'(free_cnt + FW'(1));
          end else begin
            out_err_nxt = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= '0;
    end else if (set_busy) begin
      busy_r[best_q][best_s] <= 1'b1;
    end else if (clr_busy) begin
      busy_r[cq_idx][cs_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == lsd_pkg::ST_FINISH);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == lsd_pkg::ST_FINISH) begin
      out_accepted_r <= out_accepted_nxt;
      out_cq_r       <= out_cq_nxt;
      out_cs_r       <= out_cs_nxt;
      out_slice_r    <= out_slice_nxt;
      out_load_r     <= out_load_nxt;
      out_free_r     <= out_free_nxt;
      out_err_r      <= out_err_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_accepted       = out_accepted_r;
  assign out_chosen_queue   = out_cq_r;
  assign out_chosen_slot    = out_cs_r;
  assign out_assigned_slice = out_slice_r;
  assign out_queue_load     = out_load_r;
  assign out_free_slots     = out_free_r;
  assign out_error_flag     = out_err_r;

  // A result appears only in the cycle after the sequencer finishes a word.
  a_result_follows_finish: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == lsd_pkg::ST_FINISH))
    else $error("result strobe without a finished word");

  // Every result either succeeds or reports an error, never both.
  a_accept_xor_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_accepted ^ out_error_flag))
    else $error("result is both or neither accepted and in error");

  // The slot chosen for a dispatch must still be free.
  a_chosen_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lsd_pkg::ST_FINISH && func_r == lsd_pkg::FUNC_DISPATCH && found)
      |-> !busy_r[best_q][best_s])
    else $error("dispatch chose a busy slot");

  // The free slot count cannot exceed the table size.
  a_free_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lsd_pkg::ST_FINISH) |-> (32'(free_cnt) <= TOTAL))
    else $error("free slot count out of range");

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the least loaded slot dispatcher: directed and random words.
`timescale 1ns / 1ps
module testbench;
  import lsd_pkg::*;

  localparam int NQ             = DEF_MAX_QUEUES;
  localparam int NS             = DEF_SLOTS_PER_QUEUE;
  localparam int TOTAL_ITEMS    = 1650;
  localparam int FINAL_STRETCH  = 150;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 100;
  localparam logic [UNIT_W-1:0] UNIT_MAX = '1;

  typedef struct {
    logic                  accepted;
    logic [SEL_W-1:0]      chosen_queue;
    logic [SEL_W-1:0]      chosen_slot;
    logic [SLICE_W-1:0]    assigned_slice;
    logic [LOAD_W-1:0]     queue_load;
    logic [FREE_OUT_W-1:0] free_slots;
    logic                  error_flag;
  } dispatch_result_t;

  class dispatch_scoreboard;
    logic               slot_busy [NQ][NS];
    logic [SLICE_W-1:0] slot_slice [NQ][NS];
    int                 jobs [NQ];
    logic [AQ_W-1:0]    active_queues;
    logic [UNIT_W-1:0]  slice_unit;
    dispatch_result_t   expected_results [$];
    int                 errors;
    int                 results_seen;

    function new();
      active_queues = ACTIVE_QUEUES_RST;
      slice_unit    = SLICE_UNIT_RST;
      errors        = 0;
      results_seen  = 0;
      foreach (slot_busy[q, s]) begin
        slot_busy[q][s]  = 1'b0;
        slot_slice[q][s] = '0;
      end
      foreach (jobs[q]) jobs[q] = 0;
    endfunction

    function int queues_in_use();
      return (active_queues > NQ) ? NQ : int'(active_queues);
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void apply_register(logic idx, logic [UNIT_W-1:0] data);
      if (idx == CFG_ACTIVE_QUEUES) begin
        active_queues = data[AQ_W-1:0];
      end else begin
        slice_unit = data;
      end
    endfunction

    function logic [SLICE_W-1:0] slice_for(logic [1:0] prio);
      logic [LOAD_W-1:0] unit;
      unit = LOAD_W'(slice_unit);
      case (prio)
        PRIO_HIGH: return SLICE_W'(unit * 6);
        PRIO_MID:  return SLICE_W'(unit * 4);
        PRIO_LOW:  return SLICE_W'(unit * 2);
        default:   return '0;
      endcase
    endfunction

    function logic [LOAD_W-1:0] load_score(int q);
      logic [LOAD_W-1:0] sum;
      sum = '0;
      for (int s = 0; s < NS; s++) begin
        if (slot_busy[q][s]) begin
          sum += (slot_slice[q][s] == '0) ? ZERO_SLICE_SCORE : LOAD_W'(slot_slice[q][s]);
        end
      end
      return sum;
    endfunction

    function int free_count();
      int n;
      n = 0;
      for (int q = 0; q < queues_in_use(); q++) begin
        for (int s = 0; s < NS; s++) begin
          if (!slot_busy[q][s]) n++;
        end
      end
      return n;
    endfunction

    function void note_item(logic func, logic [1:0] prio, logic [SEL_W-1:0] qsel,
                            logic [SEL_W-1:0] ssel);
      dispatch_result_t  r;
      int                nq;
      int                best;
      int                slot;
      bit                found;
      logic [LOAD_W-1:0] best_load;
      logic [LOAD_W-1:0] sc;
      r         = '{default: '0};
      nq        = queues_in_use();
      best      = 0;
      slot      = NS;
      found     = 1'b0;
      best_load = '0;
      if (func == FUNC_DISPATCH) begin
        for (int q = 0; q < nq; q++) begin
          if (jobs[q] < NS) begin
            sc = load_score(q);
            if (!found || sc < best_load) begin
              found     = 1'b1;
              best      = q;
              best_load = sc;
            end
          end
        end
        if (found) begin
          for (int s = NS - 1; s >= 0; s--) begin
            if (!slot_busy[best][s]) slot = s;
          end
        end
        if (found && slot < NS) begin
          r.accepted             = 1'b1;
          r.chosen_queue         = SEL_W'(best);
          r.chosen_slot          = SEL_W'(slot);
          r.assigned_slice       = slice_for(prio);
          r.queue_load           = best_load;
          slot_busy[best][slot]  = 1'b1;
          slot_slice[best][slot] = r.assigned_slice;
          jobs[best]++;
        end else begin
          r.error_flag = 1'b1;
        end
      end else begin
        if (int'(qsel) < nq && int'(ssel) < NS && slot_busy[qsel][ssel]) begin
          slot_busy[qsel][ssel] = 1'b0;
          if (jobs[qsel] > 0) jobs[qsel]--;
          r.accepted = 1'b1;
        end else begin
          r.error_flag = 1'b1;
        end
      end
      r.free_slots = FREE_OUT_W'(free_count());
      expected_results.push_back(r);
    endfunction

    function bit pick_busy(output logic [SEL_W-1:0] qsel, output logic [SEL_W-1:0] ssel);
      int cand [$];
      int k;
      qsel = '0;
      ssel = '0;
      for (int q = 0; q < queues_in_use(); q++) begin
        for (int s = 0; s < NS; s++) begin
          if (slot_busy[q][s]) cand.push_back(q * NS + s);
        end
      end
      if (cand.size() == 0) return 1'b0;
      k    = cand[$urandom_range(0, cand.size() - 1)];
      qsel = SEL_W'(k / NS);
      ssel = SEL_W'(k % NS);
      return 1'b1;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 100) $display("%0t: mismatch: %s", $time, msg);
    endtask

    task compare_field(string name, logic [LOAD_W-1:0] got, logic [LOAD_W-1:0] want);
      if (got !== want) begin
        report($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                         results_seen, name, got, want));
      end
    endtask

    task check_result(dispatch_result_t got);
      dispatch_result_t want;
      results_seen++;
      if (expected_results.size() == 0) begin
        report($sformatf("result %0d arrived with nothing outstanding", results_seen));
        return;
      end
      want = expected_results.pop_front();
      compare_field("accepted", LOAD_W'(got.accepted), LOAD_W'(want.accepted));
      compare_field("chosen_queue", LOAD_W'(got.chosen_queue), LOAD_W'(want.chosen_queue));
      compare_field("chosen_slot", LOAD_W'(got.chosen_slot), LOAD_W'(want.chosen_slot));
      compare_field("assigned_slice", LOAD_W'(got.assigned_slice),
                    LOAD_W'(want.assigned_slice));
      compare_field("queue_load", got.queue_load, want.queue_load);
      compare_field("free_slots", LOAD_W'(got.free_slots), LOAD_W'(want.free_slots));
      compare_field("error_flag", LOAD_W'(got.error_flag), LOAD_W'(want.error_flag));
    endtask
  endclass

  logic                  clk             = 1'b0;
  logic                  rst_n           = 1'b0;
  logic                  start           = 1'b0;
  logic                  in_func         = 1'b0;
  logic [1:0]            in_priority_req = '0;
  logic [SEL_W-1:0]      in_queue_sel    = '0;
  logic [SEL_W-1:0]      in_slot_sel     = '0;
  logic                  cfg_valid       = 1'b0;
  logic                  cfg_index       = 1'b0;
  logic [UNIT_W-1:0]     cfg_data        = '0;
  logic                  busy;
  logic                  out_valid;
  logic                  out_accepted;
  logic [SEL_W-1:0]      out_chosen_queue;
  logic [SEL_W-1:0]      out_chosen_slot;
  logic [SLICE_W-1:0]    out_assigned_slice;
  logic [LOAD_W-1:0]     out_queue_load;
  logic [FREE_OUT_W-1:0] out_free_slots;
  logic                  out_error_flag;
  logic                  cfg_ready;
  int                    idle_cycles     = 0;

  dispatch_scoreboard sb;

  least_loaded_slot_dispatcher_unit uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_func            (in_func),
    .in_priority_req    (in_priority_req),
    .in_queue_sel       (in_queue_sel),
    .in_slot_sel        (in_slot_sel),
    .out_valid          (out_valid),
    .out_accepted       (out_accepted),
    .out_chosen_queue   (out_chosen_queue),
    .out_chosen_slot    (out_chosen_slot),
    .out_assigned_slice (out_assigned_slice),
    .out_queue_load     (out_queue_load),
    .out_free_slots     (out_free_slots),
    .out_error_flag     (out_error_flag),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    dispatch_result_t seen;
    if (rst_n && out_valid) begin
      seen.accepted       = out_accepted;
      seen.chosen_queue   = out_chosen_queue;
      seen.chosen_slot    = out_chosen_slot;
      seen.assigned_slice = out_assigned_slice;
      seen.queue_load     = out_queue_load;
      seen.free_slots     = out_free_slots;
      seen.error_flag     = out_error_flag;
      sb.check_result(seen);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("testbench NOT OK");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_item(logic func, logic [1:0] prio, logic [SEL_W-1:0] qsel,
                           logic [SEL_W-1:0] ssel);
    start           <= 1'b1;
    in_func         <= func;
    in_priority_req <= prio;
    in_queue_sel    <= qsel;
    in_slot_sel     <= ssel;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(func, prio, qsel, ssel);
  endtask

  task automatic dispatch(logic [1:0] prio);
    send_item(FUNC_DISPATCH, prio, SEL_W'($urandom), SEL_W'($urandom));
  endtask

  task automatic complete(logic [SEL_W-1:0] qsel, logic [SEL_W-1:0] ssel);
    send_item(FUNC_COMPLETE, 2'($urandom), qsel, ssel);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0 || busy);
  endtask

  task automatic cfg_write(logic idx, logic [UNIT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.apply_register(idx, data);
  endtask

  task automatic set_config(logic [UNIT_W-1:0] aq_word, logic [UNIT_W-1:0] unit);
    cfg_write(CFG_ACTIVE_QUEUES, aq_word);
    cfg_write(CFG_SLICE_UNIT, unit);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int                sent;
    int                n;
    int                bias;
    int                idle_rate;
    int                roll;
    int                nq;
    int                mode;
    bit                calm;
    logic [SEL_W-1:0]  q_pick;
    logic [SEL_W-1:0]  s_pick;
    logic [UNIT_W-1:0] aq_word;
    logic [UNIT_W-1:0] unit;

    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset configuration: one job per priority, then good and bad completions.
    dispatch(PRIO_NONE);
    dispatch(PRIO_HIGH);
    dispatch(PRIO_MID);
    dispatch(PRIO_LOW);
    complete(3'd0, 3'd0);
    complete(3'd0, 3'd0);
    complete(3'd7, 3'd7);

    // One queue with the largest unit: fill it, get refused, touch an inactive queue.
    drain();
    set_config(UNIT_W'(1), UNIT_MAX);
    repeat (NS) dispatch(PRIO_HIGH);
    dispatch(PRIO_LOW);
    complete(3'd1, 3'd0);
    complete(3'd0, 3'd7);

    drain();
    set_config(UNIT_W'(0), UNIT_W'(1));
    dispatch(PRIO_MID);
    complete(3'd0, 3'd0);

    // A count above the table size is clamped; queue 1 kept its job while inactive.
    drain();
    set_config(UNIT_W'(15), UNIT_W'(1));
    complete(3'd1, 3'd0);
    dispatch(PRIO_NONE);

    sent = 0;
    while (sent < TOTAL_ITEMS) begin
      n = $urandom_range(30, 120);
      if (sent + n + FINAL_STRETCH > TOTAL_ITEMS) n = TOTAL_ITEMS - sent;
      calm = (sent + n >= TOTAL_ITEMS);
      case ($urandom_range(0, 4))
        0:       bias = 25;
        1:       bias = 50;
        2:       bias = 60;
        3:       bias = 80;
        default: bias = 95;
      endcase
      case ($urandom_range(0, 2))
        0:       idle_rate = 0;
        1:       idle_rate = 20;
        default: idle_rate = 50;
      endcase
      if (calm) idle_rate = 0;

      aq_word = ($urandom_range(0, 1) == 0) ? UNIT_W'($urandom) : '0;
      roll = $urandom_range(0, 19);
      if (roll == 0) begin
        aq_word[AQ_W-1:0] = '0;
      end else if (roll == 1) begin
        aq_word[AQ_W-1:0] = AQ_W'($urandom_range(9, 15));
      end else begin
        aq_word[AQ_W-1:0] = AQ_W'($urandom_range(1, NQ));
      end
      case ($urandom_range(0, 9))
        0:       unit = UNIT_W'(1);
        1:       unit = UNIT_MAX;
        2:       unit = SLICE_UNIT_RST;
        3, 4, 5: unit = UNIT_W'($urandom_range(1, 1000));
        default: unit = UNIT_W'($urandom_range(1, UNIT_MAX));
      endcase

      drain();
      set_config(aq_word, unit);

      repeat (n) begin
        if ($urandom_range(0, 99) < bias) begin
          dispatch(2'($urandom));
        end else begin
          roll = $urandom_range(0, 99);
          nq   = sb.queues_in_use();
          if (roll < 65 && sb.pick_busy(q_pick, s_pick)) begin
            complete(q_pick, s_pick);
          end else if (roll < 80 && nq > 0) begin
            complete(SEL_W'($urandom_range(0, nq - 1)), SEL_W'($urandom));
          end else begin
            complete(SEL_W'($urandom), SEL_W'($urandom));
          end
        end

        mode = ($urandom_range(0, 99) < idle_rate) ? $urandom_range(1, 2) : 0;
        if (mode == 1) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 18)) @(posedge clk);
        end else if (mode == 2) begin
          start <= 1'b0;
          @(posedge clk);
          while (busy) @(posedge clk);
          repeat ($urandom_range(1, 18)) @(posedge clk);
        end
      end
      sent += n;
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/lsd_pkg.sv
rtl/core/lsd_slice_mem.sv
rtl/core/lsd_score_unit.sv
rtl/core/least_loaded_slot_dispatcher_unit.sv
tb/sv/testbench.sv
